/* rtl/complex_arithmetic_unit_defines.svh */
// assertion macros for the complex arithmetic unit
// expects i_clk and i_rst_n in the scope of use; no other dependencies
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
// checked while out of reset
`define CAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("complex arithmetic unit assertion failed");
// checked at every edge, reset included
`define CAU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("complex arithmetic unit assertion failed");
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/cau_pkg.sv */
// shared types and constants of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package cau_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DW  = 32;        // operand and result part width
    localparam int PW  = 2 * DW;    // product and squared magnitude width
    localparam int SW  = PW + 1;    // signed sum of two products
    localparam int RW  = PW + DW;   // divider remainder
    localparam int QW  = DW;        // quotient and root bits
    localparam int KW  = $clog2(QW);
    localparam int NIT = QW + 1;    // range check plus one stage per bit

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_CONJ = 3'd4;
    localparam logic [2:0] MODE_MAG2 = 3'd5;
    localparam logic [2:0] MODE_MAG  = 3'd6;

    typedef struct packed {
        logic [2:0]             mode;
        logic signed [DW-1:0]   a_re;
        logic signed [DW-1:0]   a_im;
        logic signed [DW-1:0]   b_re;
        logic signed [DW-1:0]   b_im;
    } t_cau_in;

    typedef struct packed {
        logic signed [DW-1:0]   res_re;
        logic signed [DW-1:0]   res_im;
        logic                   overflow;
        logic                   div_zero;
    } t_cau_out;

    // work carried through the divide and root stages
    typedef struct packed {
        t_cau_out       res;
        logic           is_div;
        logic           is_mag;
        logic           neg_re;
        logic           neg_im;
        logic           cap_re;
        logic           cap_im;
        logic [RW-1:0]  num_re;
        logic [RW-1:0]  num_im;
        logic [PW-1:0]  den;
        logic [QW-1:0]  q_re;
        logic [QW-1:0]  q_im;
        logic [SW-1:0]  rem;
        logic [QW-1:0]  root;
    } t_cau_iter;

endpackage

/* rtl/complex_arithmetic_unit.sv */
// complex arithmetic unit top level: pipelined complex alu on q16.16 operands
// depends on cau_pkg and complex_arithmetic_unit_defines.svh
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_defines.svh"

// usage
//   input channel: i_in_valid / o_in_ready carry one request (mode, a, b)
//   output channel: o_out_valid / i_out_ready carry one result per request
//   modes: add, subtract, multiply, divide, conjugate of a, |a|^2, |a|
//   every mode passes through the same stages from acceptance to o_out_valid
//   throughput: one request per cycle while the receiver keeps up; the
//   divider and root spend one pipeline stage per quotient or root bit
//   (32 stages plus one range check), re and im dividers and root side by side
//   stages: operand products, product sums, sign and scaling, 33 bit stages,
//   output register; every stage has its own valid bit
//   stall: a stage holds while the one after it is full and stalled, so
//   empty stages keep filling and o_in_ready only drops once the whole
//   pipeline is full behind a stalled receiver; nothing is lost or repeated
//   reset: synchronous, active low, empties every stage; payload registers
//   are not reset
//   overflowing parts saturate and set overflow; a zero divisor returns zero
//   with div_zero set; unused mode code returns zero
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_cau_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_cau_out o_out_data
);

    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (DW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (DW - 1));

    // saturate a wide signed value to one result part, overflow flag on top
    function automatic logic [DW:0] sat_s(input logic signed [SW-1:0] v);
        logic [DW:0] r;
        if (v > SAT_HI) begin
            r = {1'b1, SAT_HI[DW-1:0]};
        end else if (v < SAT_LO) begin
            r = {1'b1, SAT_LO[DW-1:0]};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

    // signed value from sign, quotient and the capped-quotient flag
    function automatic logic signed [SW-1:0] q_signed(input logic neg, input logic cap,
                                                      input logic [QW-1:0] q);
        logic [SW-1:0] m;
        m = cap ? (SW'(1) << QW) : SW'(q);
        return neg ? $signed(-m) : $signed(m);
    endfunction

    // quotient range check: quotient of 2^32 or more only saturates
    function automatic t_cau_iter iter_cap(input t_cau_iter s);
        t_cau_iter n;
        n = s;
        n.cap_re = s.num_re >= (RW'(s.den) << QW);
        n.cap_im = s.num_im >= (RW'(s.den) << QW);
        return n;
    endfunction

    // one restoring step of both dividers and of the root
    function automatic t_cau_iter iter_step(input t_cau_iter s, input logic [KW-1:0] k);
        t_cau_iter     n;
        logic [RW-1:0] t_d;
        logic [SW-1:0] t_s;
        n   = s;
        t_d = RW'(s.den) << k;
        if (s.num_re >= t_d) begin
            n.num_re = s.num_re - t_d;
            n.q_re[k] = 1'b1;
        end
        if (s.num_im >= t_d) begin
            n.num_im = s.num_im - t_d;
            n.q_im[k] = 1'b1;
        end
        // (root + 2^k)^2 - root^2
        t_s = ((SW'(s.root) << k) << 1) + ((SW'(1) << k) << k);
        if (s.rem >= t_s) begin
            n.rem = s.rem - t_s;
            n.root[k] = 1'b1;
        end
        return n;
    endfunction

    // handshake chain: a stage loads when it is empty or moves on itself
    logic            r_s1_v, r_s2_v, r_s3_v, r_out_valid;
    logic [NIT-1:0]  r_it_v;
    logic            w_go_s1, w_go_s2, w_go_s3, w_go_out;
    logic [NIT-1:0]  w_go_it;

    assign w_go_out         = !r_out_valid || i_out_ready;
    assign w_go_it[NIT-1]   = !r_it_v[NIT-1] || w_go_out;
    for (genvar j = 0; j < NIT - 1; j++) begin : g_go
        assign w_go_it[j] = !r_it_v[j] || w_go_it[j+1];
    end
    assign w_go_s3    = !r_s3_v || w_go_it[0];
    assign w_go_s2    = !r_s2_v || w_go_s3;
    assign w_go_s1    = !r_s1_v || w_go_s2;
    assign o_in_ready = w_go_s1;

    // stage 1: the four cross products, the two squares, simple modes
    logic [2:0]             r_s1_mode;
    logic signed [PW-1:0]   r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_re, r_sq_im;
    t_cau_out               r_s1_res, n_s1_res;
    logic signed [DW-1:0]   w_x_re, w_x_im;
    logic signed [DW:0]     w_sum_re, w_sum_im;
    logic [DW:0]            w_sat_a, w_sat_b;

    // squares come from b for divide, from a otherwise
    assign w_x_re = (i_in_data.mode == MODE_DIV) ? i_in_data.b_re : i_in_data.a_re;
    assign w_x_im = (i_in_data.mode == MODE_DIV) ? i_in_data.b_im : i_in_data.a_im;

    always_comb begin
        n_s1_res = '0;
        if (i_in_data.mode == MODE_SUB) begin
            w_sum_re = (DW+1)'(i_in_data.a_re) - (DW+1)'(i_in_data.b_re);
            w_sum_im = (DW+1)'(i_in_data.a_im) - (DW+1)'(i_in_data.b_im);
        end else begin
            w_sum_re = (DW+1)'(i_in_data.a_re) + (DW+1)'(i_in_data.b_re);
            w_sum_im = (DW+1)'(i_in_data.a_im) + (DW+1)'(i_in_data.b_im);
        end
        w_sat_a = sat_s(SW'(w_sum_re));
        w_sat_b = sat_s(SW'(w_sum_im));
        case (i_in_data.mode)
            MODE_ADD, MODE_SUB: begin
                n_s1_res.res_re   = w_sat_a[DW-1:0];
                n_s1_res.res_im   = w_sat_b[DW-1:0];
                n_s1_res.overflow = w_sat_a[DW] | w_sat_b[DW];
            end
            MODE_CONJ: begin
                // negating the most negative part saturates
                n_s1_res.res_re   = i_in_data.a_re;
                n_s1_res.res_im   = w_sat_b[DW-1:0];
                n_s1_res.overflow = w_sat_b[DW];
            end
            default: begin
                n_s1_res = '0;
            end
        endcase
        if (i_in_data.mode == MODE_CONJ) begin
            w_sat_b           = sat_s(-SW'(i_in_data.a_im));
            n_s1_res.res_im   = w_sat_b[DW-1:0];
            n_s1_res.overflow = w_sat_b[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_go_s1) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go_s1) begin
            r_s1_mode <= i_in_data.mode;
            r_p_rr    <= PW'(i_in_data.a_re) * PW'(i_in_data.b_re);
            r_p_ii    <= PW'(i_in_data.a_im) * PW'(i_in_data.b_im);
            r_p_ri    <= PW'(i_in_data.a_re) * PW'(i_in_data.b_im);
            r_p_ir    <= PW'(i_in_data.a_im) * PW'(i_in_data.b_re);
            r_sq_re   <= PW'(w_x_re) * PW'(w_x_re);
            r_sq_im   <= PW'(w_x_im) * PW'(w_x_im);
            r_s1_res  <= n_s1_res;
        end
    end

    // stage 2: product sums and squared magnitude
    logic [2:0]             r_s2_mode;
    logic signed [SW-1:0]   r_s2_sr, r_s2_si, n_s2_sr, n_s2_si;
    logic [PW-1:0]          r_s2_sq;
    t_cau_out               r_s2_res;

    always_comb begin
        if (r_s1_mode == MODE_DIV) begin
            // a * conj(b)
            n_s2_sr = SW'(r_p_rr) + SW'(r_p_ii);
            n_s2_si = SW'(r_p_ir) - SW'(r_p_ri);
        end else begin
            n_s2_sr = SW'(r_p_rr) - SW'(r_p_ii);
            n_s2_si = SW'(r_p_ri) + SW'(r_p_ir);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_go_s2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go_s2) begin
            r_s2_mode <= r_s1_mode;
            r_s2_sr   <= n_s2_sr;
            r_s2_si   <= n_s2_si;
            r_s2_sq   <= $unsigned(r_sq_re) + $unsigned(r_sq_im);
            r_s2_res  <= r_s1_res;
        end
    end

    // stage 3: scaling for multiply and |a|^2, set-up of divider and root
    t_cau_iter      r_s3, n_s3;
    logic [SW-1:0]  w_abs_re, w_abs_im;
    logic [DW:0]    w_s3_a, w_s3_b;

    assign w_abs_re = r_s2_sr[SW-1] ? $unsigned(-r_s2_sr) : $unsigned(r_s2_sr);
    assign w_abs_im = r_s2_si[SW-1] ? $unsigned(-r_s2_si) : $unsigned(r_s2_si);

    always_comb begin
        n_s3     = '0;
        n_s3.res = r_s2_res;
        w_s3_a   = sat_s(r_s2_sr >>> FRAC_BITS);
        w_s3_b   = sat_s(r_s2_si >>> FRAC_BITS);
        case (r_s2_mode)
            MODE_MUL: begin
                n_s3.res.res_re   = w_s3_a[DW-1:0];
                n_s3.res.res_im   = w_s3_b[DW-1:0];
                n_s3.res.overflow = w_s3_a[DW] | w_s3_b[DW];
            end
            MODE_MAG2: begin
                w_s3_a            = sat_s($signed({1'b0, r_s2_sq >> FRAC_BITS}));
                n_s3.res.res_re   = w_s3_a[DW-1:0];
                n_s3.res.res_im   = '0;
                n_s3.res.overflow = w_s3_a[DW];
            end
            MODE_DIV: begin
                if (r_s2_sq == '0) begin
                    n_s3.res          = '0;
                    n_s3.res.div_zero = 1'b1;
                end else begin
                    n_s3.is_div = 1'b1;
                    n_s3.neg_re = r_s2_sr[SW-1];
                    n_s3.neg_im = r_s2_si[SW-1];
                    n_s3.num_re = RW'(w_abs_re[PW-1:0]) << FRAC_BITS;
                    n_s3.num_im = RW'(w_abs_im[PW-1:0]) << FRAC_BITS;
                    n_s3.den    = r_s2_sq;
                end
            end
            MODE_MAG: begin
                n_s3.is_mag = 1'b1;
                n_s3.rem    = {1'b0, r_s2_sq};
                n_s3.res    = '0;
            end
            default: begin
                n_s3.res = r_s2_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_go_s3) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go_s3) begin
            r_s3 <= n_s3;
        end
    end

    // bit stages: range check, then quotient and root bits msb first
    t_cau_iter      r_it [NIT];
    t_cau_iter      w_src [NIT];
    t_cau_iter      n_it [NIT];
    logic [NIT-1:0] w_src_v;

    assign w_src_v = {r_it_v[NIT-2:0], r_s3_v};

    for (genvar j = 0; j < NIT; j++) begin : g_it
        if (j == 0) begin : g_first
            assign w_src[j] = r_s3;
            assign n_it[j]  = iter_cap(w_src[j]);
        end else begin : g_bit
            assign w_src[j] = r_it[j-1];
            assign n_it[j]  = iter_step(w_src[j], KW'(QW - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_v <= '0;
        end else begin
            for (int j = 0; j < NIT; j++) begin
                if (w_go_it[j]) begin
                    r_it_v[j] <= w_src_v[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NIT; j++) begin
            if (w_go_it[j]) begin
                r_it[j] <= n_it[j];
            end
        end
    end

    // output register: final saturation of quotients and root
    t_cau_out       r_out, n_out;
    t_cau_iter      w_last;
    logic [DW:0]    w_o_a, w_o_b;

    assign w_last = r_it[NIT-1];

    always_comb begin
        n_out = w_last.res;
        w_o_a = sat_s(q_signed(w_last.neg_re, w_last.cap_re, w_last.q_re));
        w_o_b = sat_s(q_signed(w_last.neg_im, w_last.cap_im, w_last.q_im));
        if (w_last.is_div) begin
            n_out.res_re   = w_o_a[DW-1:0];
            n_out.res_im   = w_o_b[DW-1:0];
            n_out.overflow = w_o_a[DW] | w_o_b[DW];
            n_out.div_zero = 1'b0;
        end else if (w_last.is_mag) begin
            w_o_a          = sat_s(SW'(w_last.root));
            n_out.res_re   = w_o_a[DW-1:0];
            n_out.res_im   = '0;
            n_out.overflow = w_o_a[DW];
            n_out.div_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go_out) begin
            r_out_valid <= r_it_v[NIT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `CAU_ASSERT(a_dz_result_zero, o_out_valid && o_out_data.div_zero |-> o_out_data.res_re == '0 && o_out_data.res_im == '0 && !o_out_data.overflow)
    `CAU_ASSERT(a_accept_enters, i_in_valid && o_in_ready |=> r_s1_v)
    `CAU_ASSERT(a_last_stage_holds, r_it_v[NIT-1] && !w_go_it[NIT-1] |=> r_it_v[NIT-1] && r_out_valid)
    `CAU_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid && !r_s1_v)

endmodule

/* dv/cau_checker.sv */
// checker for the complex arithmetic unit: watches both channels, predicts each result
// depends on cau_pkg
`timescale 1ns / 1ps

module cau_checker import cau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_cau_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_cau_out i_out_data,
    output int       o_err_count,
    output int       o_pending
);

    t_cau_out result_q[$];
    int       err_count = 0;

    assign o_err_count = err_count;
    assign o_pending   = result_q.size();

    // clamp a wide signed value to 32 bits
    function automatic logic [31:0] clamp32(input logic signed [95:0] v, inout logic ov);
        if (v > 96'sd2147483647) begin
            ov = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -96'sd2147483648) begin
            ov = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // truncating fractional divide, sign applied afterwards
    function automatic logic signed [95:0] tdiv(input logic signed [95:0] num,
                                                input logic signed [95:0] den);
        logic [95:0] mag;
        logic [95:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag << FRAC_BITS) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] bitv;
        r    = 0;
        bitv = 64'h1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r[31:0];
    endfunction

    function automatic t_cau_out predict_result(input t_cau_in d);
        t_cau_out o;
        logic signed [95:0] ar, ai, br, bi, sr, si, den;
        logic ov;
        ar = d.a_re; ai = d.a_im; br = d.b_re; bi = d.b_im;
        ov = 1'b0;
        o  = '0;
        case (d.mode)
            MODE_ADD: begin
                o.res_re = clamp32(ar + br, ov);
                o.res_im = clamp32(ai + bi, ov);
            end
            MODE_SUB: begin
                o.res_re = clamp32(ar - br, ov);
                o.res_im = clamp32(ai - bi, ov);
            end
            MODE_MUL: begin
                // arithmetic shift floors
                sr = ar * br - ai * bi;
                si = ar * bi + ai * br;
                o.res_re = clamp32(sr >>> FRAC_BITS, ov);
                o.res_im = clamp32(si >>> FRAC_BITS, ov);
            end
            MODE_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    o.div_zero = 1'b1;
                end else begin
                    o.res_re = clamp32(tdiv(ar * br + ai * bi, den), ov);
                    o.res_im = clamp32(tdiv(ai * br - ar * bi, den), ov);
                end
            end
            MODE_CONJ: begin
                o.res_re = d.a_re;
                o.res_im = clamp32(-ai, ov);
            end
            MODE_MAG2: o.res_re = clamp32((ar * ar + ai * ai) >>> FRAC_BITS, ov);
            MODE_MAG: begin
                sr = ar * ar + ai * ai;
                o.res_re = clamp32({64'd0, root64(sr[63:0])}, ov);
            end
            default: ;
        endcase
        o.overflow = ov;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_cau_out exp_r;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                result_q.push_back(predict_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with nothing expected");
                    err_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r.res_re !== i_out_data.res_re) begin
                        $error("res_re expected %h actual %h", exp_r.res_re, i_out_data.res_re);
                        err_count++;
                    end
                    if (exp_r.res_im !== i_out_data.res_im) begin
                        $error("res_im expected %h actual %h", exp_r.res_im, i_out_data.res_im);
                        err_count++;
                    end
                    if (exp_r.overflow !== i_out_data.overflow) begin
                        $error("overflow expected %b actual %b",
                               exp_r.overflow, i_out_data.overflow);
                        err_count++;
                    end
                    if (exp_r.div_zero !== i_out_data.div_zero) begin
                        $error("div_zero expected %b actual %b",
                               exp_r.div_zero, i_out_data.div_zero);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

/* dv/tb.sv */
// testbench top for the complex arithmetic unit: clock, reset, requests and verdict
// depends on cau_pkg, complex_arithmetic_unit and cau_checker
`timescale 1ns / 1ps

module tb;
    import cau_pkg::*;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_cau_in  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_cau_out out_data;
    int       err_count;
    int       pending;

    // idle percentages, changed per phase
    int       send_idle = 0;
    int       recv_idle = 0;
    // long hold-off of the receiver to fill the pipeline
    bit       hold_req = 0;

    complex_arithmetic_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    cau_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_req)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // pick an operand part: extremes often, otherwise random or small
    function automatic logic [31:0] pick_part();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            4: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until accepted
    task automatic send_req(input t_cau_in d);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        t_cau_in d;
        for (int k = 0; k < n; k++) begin
            d.mode = 3'($urandom_range(7));
            d.a_re = pick_part();
            d.a_im = pick_part();
            d.b_re = pick_part();
            d.b_im = pick_part();
            // zero divisor now and then
            if (d.mode == MODE_DIV && $urandom_range(15) == 0) begin
                d.b_re = 0;
                d.b_im = 0;
            end
            send_req(d);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    initial begin
        t_cau_in d;
        logic [31:0] ext [4];
        ext[0] = 32'h7fffffff; ext[1] = 32'h80000000;
        ext[2] = 32'h0;        ext[3] = 32'h00010000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode on the extremes, zero divisor, unused mode
        for (int m = 0; m < 8; m++) begin
            d.mode = 3'(m);
            d.a_re = ext[m % 4]; d.a_im = ext[1];
            d.b_re = ext[(m + 1) % 4]; d.b_im = ext[(m + 2) % 4];
            send_req(d);
            d.a_re = ext[0]; d.a_im = ext[0]; d.b_re = ext[1]; d.b_im = ext[1];
            send_req(d);
        end
        d = '0; d.mode = MODE_DIV; d.a_re = 32'h00050000;
        send_req(d);
        d.b_re = 32'h00000001;
        send_req(d);
        d = '0; d.mode = MODE_CONJ; d.a_im = 32'h80000000;
        send_req(d);

        send_idle = 0;  recv_idle = 0;  send_random(500);
        send_idle = 59; recv_idle = 0;  send_random(400);
        send_idle = 0;  recv_idle = 59; send_random(400);
        send_idle = 18; recv_idle = 18; send_random(400);

        // long receiver hold-off while requests keep coming
        send_idle = 0; recv_idle = 0;
        fork
            begin
                hold_req = 1;
                repeat (120) @(posedge i_clk);
                hold_req = 0;
            end
            send_random(200);
        join
        drain();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
